// ===== rtl/jsu_pkg.sv =====
// jsu_pkg: shared types and constants for the JSON string unescaper.
// Used by jsu_decode and json_string_unescape; no dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

  // Decoder modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TEXT = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  // Most results one input item can cause: three UTF-8 bytes plus done
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_CW  = $clog2(MAX_RES + 1);
  localparam int unsigned RES_IW  = $clog2(MAX_RES);

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  hex_count;
    logic [15:0] hex_value;
    logic        prefix_open;
  } jsu_state_t;

  typedef struct packed {
    logic [RES_CW-1:0]          count;
    logic [MAX_RES-1:0][7:0]    byte_v;
    logic [MAX_RES-1:0]         done_v;
  } jsu_res_t;

endpackage

// ===== rtl/jsu_decode.sv =====
// jsu_decode: one step of the unescape state machine for a single byte.
// Produces the next decoder state and up to four result items. Uses jsu_pkg.
`timescale 1ns / 1ps

module jsu_decode (
  input  jsu_pkg::jsu_state_t st_i,
  input  logic [7:0]          in_byte,
  input  logic                start_req,
  input  logic                final_byte,
  output jsu_pkg::jsu_state_t st_o,
  output jsu_pkg::jsu_res_t   res_o
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Hex digit test: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  logic [4:0]        dig;
  logic [15:0]       cp;
  logic [RES_CW-1:0] n;
  jsu_state_t        s;

  assign dig = hex_digit(in_byte);

  always_comb begin
    s = st_i;
    n = '0;
    cp = '0;
    res_o.byte_v = '0;
    res_o.done_v = '0;
    if (start_req) begin
      s.mode = MODE_TEXT;
      s.hex_count = 2'd0;
      s.hex_value = 16'd0;
      s.prefix_open = 1'b1;
    end
    if (s.mode != MODE_IDLE) begin
      case (s.mode)
        MODE_TEXT: begin
          if (in_byte == CH_QUOTE) begin
            res_o.done_v[0] = 1'b1;
            n = RES_CW'(1);
            s.mode = MODE_IDLE;
          end else if (in_byte == CH_BSLASH) begin
            s.mode = MODE_ESC;
          end else begin
            res_o.byte_v[0] = in_byte;
            n = RES_CW'(1);
          end
        end
        MODE_ESC: begin
          s.mode = MODE_TEXT;
          res_o.byte_v[0] = in_byte;
          n = RES_CW'(1);
          case (in_byte)
            CH_B: res_o.byte_v[0] = 8'h08;
            CH_F: res_o.byte_v[0] = 8'h0C;
            CH_N: res_o.byte_v[0] = 8'h0A;
            CH_R: res_o.byte_v[0] = 8'h0D;
            CH_T: res_o.byte_v[0] = 8'h09;
            CH_U: begin
              s.mode = MODE_HEX;
              s.hex_count = 2'd0;
              s.hex_value = 16'd0;
              s.prefix_open = 1'b1;
              res_o.byte_v[0] = 8'h00;
              n = '0;
            end
            default: ;
          endcase
        end
        default: begin  // gathering hex
          if (s.prefix_open && dig[4]) s.hex_value = {s.hex_value[11:0], dig[3:0]};
          else                         s.prefix_open = 1'b0;
          if (s.hex_count == 2'd3) begin
            cp = s.hex_value;
            if (cp < 16'h0080) begin
              res_o.byte_v[0] = cp[7:0];
              n = RES_CW'(1);
            end else if (cp < 16'h0800) begin
              res_o.byte_v[0] = {3'b110, cp[10:6]};
              res_o.byte_v[1] = {2'b10, cp[5:0]};
              n = RES_CW'(2);
            end else begin
              res_o.byte_v[0] = {4'b1110, cp[15:12]};
              res_o.byte_v[1] = {2'b10, cp[11:6]};
              res_o.byte_v[2] = {2'b10, cp[5:0]};
              n = RES_CW'(3);
            end
            s.mode = MODE_TEXT;
            s.hex_count = 2'd0;
            s.hex_value = 16'd0;
            s.prefix_open = 1'b1;
          end else begin
            s.hex_count = s.hex_count + 2'd1;
          end
        end
      endcase
      // Buffer end closes the string; a partial escape emits nothing
      if (final_byte && s.mode != MODE_IDLE) begin
        res_o.done_v[n[RES_IW-1:0]] = 1'b1;
        res_o.byte_v[n[RES_IW-1:0]] = 8'h00;
        n = n + RES_CW'(1);
        s.mode = MODE_IDLE;
        s.hex_count = 2'd0;
        s.hex_value = 16'd0;
        s.prefix_open = 1'b1;
      end
    end
    res_o.count = n;
    st_o = s;
  end

endmodule

// ===== rtl/json_string_unescape.sv =====
// json_string_unescape: top level of the JSON string body unescaper.
// Instantiates jsu_decode; uses jsu_pkg for state and result types.
`timescale 1ns / 1ps

// Feed the bytes of a JSON string body, starting with the byte after the
// opening quote (flag it with in_tuser = start_req). Plain bytes pass
// through, backslash escapes are translated, and \uXXXX is emitted as one
// to three UTF-8 bytes built from the leading hex digits. A closing quote,
// or an input item with in_tlast set (buffer end), produces a done item
// (out_tuser = 1, out_tdata = 0). out_tlast marks the last item caused by
// one input item. Each input item is decoded in the cycle it is accepted
// and its results land in a four-entry result register that drains one
// item per cycle while out_tready is high. Throughput is one input item per
// cycle while each causes at most one result and out_tready stays high; more
// results block input, and in_tready returns in the cycle the last is taken.
// Bytes arriving with no string open and no start_req are dropped silently.

module json_string_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] start_req
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] string_done
  output logic       out_tlast   // last
);
  import jsu_pkg::*;

  jsu_state_t st_r, st_nxt;
  jsu_res_t   res;

  // Result register: decoded items waiting for the output side
  logic [MAX_RES-1:0][7:0] byte_r;
  logic [MAX_RES-1:0]      done_r;
  logic [RES_CW-1:0]       count_r;   // zero means empty
  logic [RES_IW-1:0]       rd_r;

  logic in_fire, out_fire, drain_last;

  jsu_decode u_dec (
    .st_i       (st_r),
    .in_byte    (in_tdata),
    .start_req  (in_tuser),
    .final_byte (in_tlast),
    .st_o       (st_nxt),
    .res_o      (res)
  );

  assign out_tvalid = (count_r != '0);
  assign out_tdata  = byte_r[rd_r];
  assign out_tuser  = done_r[rd_r];
  assign out_tlast  = ({1'b0, rd_r} == (count_r - RES_CW'(1)));

  assign out_fire   = out_tvalid && out_tready;
  assign drain_last = out_fire && out_tlast;
  // Take a new item when the buffer is empty or its last item leaves now
  assign in_tready  = !out_tvalid || drain_last;
  assign in_fire    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode        <= MODE_IDLE;
      st_r.hex_count   <= 2'd0;
      st_r.hex_value   <= 16'd0;
      st_r.prefix_open <= 1'b1;
      count_r          <= '0;
      rd_r             <= '0;
    end else begin
      if (in_fire) st_r <= st_nxt;
      if (in_fire && res.count != '0) begin
        // load a fresh batch of results
        count_r <= res.count;
        rd_r    <= '0;
      end else if (drain_last) begin
        count_r <= '0;
        rd_r    <= '0;
      end else if (out_fire) begin
        // advance to the next buffered item
        rd_r <= rd_r + RES_IW'(1);
      end
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    if (in_fire && res.count != '0) begin
      byte_r <= res.byte_v;
      done_r <= res.done_v;
    end
  end

endmodule

// ===== rtl/jsu_checker.sv =====
// jsu_checker: port-level assertions for json_string_unescape.
// Sees only the top-level ports; attached by the bind at the end of this file.
`timescale 1ns / 1ps

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output item changed");

  // An empty output side never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output empty");

  // A done item closes its batch
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 8'h00)
    else $error("done item not last or not zero");

  // No input while a batch still has items beyond the current one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while results pending");

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
